[rtl/aiue_pkg.sv]
// ----------------------------------------------------------------------------
// ARP / ICMP / UDP echo responder package
// Shared constants, codes and helper functions of the responder.
// ----------------------------------------------------------------------------
package aiue_pkg;

    localparam int FRAME_BYTES_DEF = 512;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
    localparam logic [7:0]  ARP_OP_REPLY  = 8'h02;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TTL        = 8'd64;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;

    localparam logic [1:0] KIND_ARP  = 2'd0;
    localparam logic [1:0] KIND_ICMP = 2'd1;
    localparam logic [1:0] KIND_UDP  = 2'd2;

    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 48;
    localparam logic [2:0]  CFG_LOCAL_IP     = 3'd0;
    localparam logic [2:0]  CFG_LOCAL_MAC    = 3'd1;
    localparam logic [2:0]  CFG_ARP_ENABLE   = 3'd2;
    localparam logic [2:0]  CFG_ICMP_ENABLE  = 3'd3;
    localparam logic [2:0]  CFG_UDP_ENABLE   = 3'd4;

    localparam int SUM_W = 28;

    function automatic logic [15:0] fold_not(input logic [SUM_W-1:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = 17'(s[SUM_W-1:16]) + 17'(s[15:0]);
        s2 = 17'(s1[15:0]) + 17'(s1[16]);
        return ~s2[15:0];
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        logic [47:0] sh;
        sh = mac >> (6'd40 - {i, 3'b000});
        return sh[7:0];
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
        logic [31:0] sh;
        sh = ip >> (5'd24 - {i, 3'b000});
        return sh[7:0];
    endfunction

endpackage

[rtl/aiue_in_if.sv]
// ----------------------------------------------------------------------------
// Frame input channel
// Valid/ready channel carrying one 64-bit word of a received frame.
// ----------------------------------------------------------------------------
interface aiue_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        frame_end;

    modport source (output valid, frame_word, valid_bytes, frame_end, input ready);
    modport sink (input valid, frame_word, valid_bytes, frame_end, output ready);
endinterface

[rtl/aiue_out_if.sv]
// ----------------------------------------------------------------------------
// Reply output channel
// Valid/ready channel carrying one 64-bit word of a reply frame.
// ----------------------------------------------------------------------------
interface aiue_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] reply_word;
    logic [3:0]  reply_valid_bytes;
    logic [1:0]  reply_kind;
    logic        reply_end;

    modport source (output valid, reply_word, reply_valid_bytes, reply_kind, reply_end,
                    input ready);
    modport sink (input valid, reply_word, reply_valid_bytes, reply_kind, reply_end,
                  output ready);
endinterface

[rtl/aiue_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aiue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/arp_icmp_udp_echo_responder_unit.sv]
// ----------------------------------------------------------------------------
// ARP / ICMP / UDP echo responder
// Buffers a frame byte by byte and answers ARP, ICMP echo and UDP frames.
// ----------------------------------------------------------------------------
// Each input word is taken in S_IDLE and written in S_WR, one byte RAM write
// per cycle (at most 8 bytes counted). After the last word the header is read
// into registers, the checksums are summed and the reply is emitted, byte by
// byte through the single read port of the byte RAM and one shared adder. Reset
// is synchronous and active low; it clears the sequencer, byte count, overflow
// flag, local IP and MAC and reply valid, and enables all reply kinds.
module arp_icmp_udp_echo_responder_unit #(
    parameter int FRAME_BYTES = aiue_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aiue_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aiue_pkg::CFG_DATA_W-1:0] i_cfg_data,
    aiue_in_if.sink                         i_frame,
    aiue_out_if.source                      o_reply
);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam int HDR_BYTES = 42;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]  r_state;
    logic        r_ph;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        r_arp_en, r_icmp_en, r_udp_en;

    logic [63:0] r_word;
    logic [3:0]  r_n;
    logic [3:0]  r_k;
    logic        r_end;
    logic [PW-1:0] r_nbytes;
    logic        r_ovf;
    logic [PW-1:0] r_len;

    logic [7:0]  r_hdr [0:HDR_BYTES-1];
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_stop;
    logic [1:0]  r_kind;
    logic [15:0] r_tot;
    logic [7:0]  r_proto;
    logic [15:0] r_ipck;
    logic [15:0] r_l4ck;
    logic        r_pass;
    logic [aiue_pkg::SUM_W-1:0] r_sum;
    logic [63:0] r_acc;
    logic [2:0]  r_bi;

    logic        r_ov;
    logic [63:0] r_ow;
    logic [3:0]  r_ovb;
    logic [1:0]  r_ok;
    logic        r_oe;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [PW-1:0] src;
    logic [7:0]    rb;
    logic [63:0]   wsh;

    aiue_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign wsh       = r_word << {r_k[2:0], 3'b000};
    assign ram_we    = (r_state == S_WR) && (r_k != r_n) && (r_nbytes < PW'(FRAME_BYTES));
    assign ram_waddr = r_nbytes[AW-1:0];
    assign ram_wdata = wsh[63:56];
    assign ram_raddr = (r_state == S_HDR) ? r_pos[AW-1:0] : src[AW-1:0];

    // Source byte of the request that lands at each reply position.
    always_comb begin
        src = r_pos;
        if (r_kind == aiue_pkg::KIND_ARP) begin
            case (r_pos) inside
                [0:5]:   src = r_pos + PW'(22);
                [32:41]: src = r_pos - PW'(10);
                default: src = r_pos;
            endcase
        end else begin
            case (r_pos) inside
                [0:5]:   src = r_pos + PW'(6);
                [30:33]: src = r_pos - PW'(4);
                [34:35]: src = (r_kind == aiue_pkg::KIND_UDP) ? r_pos + PW'(2) : r_pos;
                [36:37]: src = (r_kind == aiue_pkg::KIND_UDP) ? r_pos - PW'(2) : r_pos;
                default: src = r_pos;
            endcase
        end
    end

    // Reply byte at the current position.
    always_comb begin
        rb = ram_rdata;
        if (r_kind == aiue_pkg::KIND_ARP) begin
            case (r_pos) inside
                [6:11]:  rb = aiue_pkg::mac_byte(r_mac, 3'(r_pos - PW'(6)));
                12:      rb = aiue_pkg::ETH_TYPE_ARP[15:8];
                13:      rb = aiue_pkg::ETH_TYPE_ARP[7:0];
                14:      rb = 8'h00;
                15:      rb = 8'h01;
                16:      rb = aiue_pkg::ETH_TYPE_IPV4[15:8];
                17:      rb = aiue_pkg::ETH_TYPE_IPV4[7:0];
                18:      rb = 8'd6;
                19:      rb = 8'd4;
                20:      rb = 8'h00;
                21:      rb = aiue_pkg::ARP_OP_REPLY;
                [22:27]: rb = aiue_pkg::mac_byte(r_mac, 3'(r_pos - PW'(22)));
                [28:31]: rb = aiue_pkg::ip_byte(r_ip, 2'(r_pos - PW'(28)));
                default: rb = ram_rdata;
            endcase
        end else begin
            case (r_pos) inside
                [6:11]:  rb = aiue_pkg::mac_byte(r_mac, 3'(r_pos - PW'(6)));
                12:      rb = aiue_pkg::ETH_TYPE_IPV4[15:8];
                13:      rb = aiue_pkg::ETH_TYPE_IPV4[7:0];
                14:      rb = aiue_pkg::IP_VER_IHL;
                15:      rb = 8'h00;
                16:      rb = r_tot[15:8];
                17:      rb = r_tot[7:0];
                [18:21]: rb = 8'h00;
                22:      rb = aiue_pkg::IP_TTL;
                23:      rb = r_proto;
                24:      rb = r_ipck[15:8];
                25:      rb = r_ipck[7:0];
                [26:29]: rb = aiue_pkg::ip_byte(r_ip, 2'(r_pos - PW'(26)));
                34:      rb = (r_kind == aiue_pkg::KIND_ICMP) ? aiue_pkg::ICMP_ECHO_REP
                                                              : ram_rdata;
                35:      rb = (r_kind == aiue_pkg::KIND_ICMP) ? 8'h00 : ram_rdata;
                36:      rb = (r_kind == aiue_pkg::KIND_ICMP) ? r_l4ck[15:8] : ram_rdata;
                37:      rb = (r_kind == aiue_pkg::KIND_ICMP) ? r_l4ck[7:0] : ram_rdata;
                40:      rb = (r_kind == aiue_pkg::KIND_UDP) ? r_l4ck[15:8] : ram_rdata;
                41:      rb = (r_kind == aiue_pkg::KIND_UDP) ? r_l4ck[7:0] : ram_rdata;
                default: rb = ram_rdata;
            endcase
        end
    end

    // Decode of the buffered header.
    logic [15:0] d_etype, d_op, d_tl, d_ul;
    logic [31:0] d_tpa, d_dip;
    logic        d_arp, d_icmp, d_udp, d_ipok;
    assign d_etype = {r_hdr[12], r_hdr[13]};
    assign d_op    = {r_hdr[20], r_hdr[21]};
    assign d_tl    = {r_hdr[16], r_hdr[17]};
    assign d_ul    = {r_hdr[38], r_hdr[39]};
    assign d_tpa   = {r_hdr[38], r_hdr[39], r_hdr[40], r_hdr[41]};
    assign d_dip   = {r_hdr[30], r_hdr[31], r_hdr[32], r_hdr[33]};
    assign d_ipok  = (d_etype == aiue_pkg::ETH_TYPE_IPV4) && (r_len >= PW'(34))
                     && (r_hdr[14] == aiue_pkg::IP_VER_IHL) && (d_dip == r_ip);
    assign d_arp   = !r_ovf && (d_etype == aiue_pkg::ETH_TYPE_ARP) && (r_len >= PW'(42))
                     && r_arp_en && (d_op == aiue_pkg::ARP_OP_REQ) && (d_tpa == r_ip);
    assign d_icmp  = !r_ovf && d_ipok && (r_hdr[23] == aiue_pkg::PROTO_ICMP) && r_icmp_en
                     && (d_tl >= 16'd28)
                     && ((17'(d_tl) + 17'd14) <= 17'(r_len))
                     && (r_hdr[34] == aiue_pkg::ICMP_ECHO_REQ);
    assign d_udp   = !r_ovf && d_ipok && (r_hdr[23] == aiue_pkg::PROTO_UDP) && r_udp_en
                     && (r_len >= PW'(42)) && (d_ul >= 16'd8)
                     && ((17'(d_ul) + 17'd34) <= 17'(r_len));

    assign i_frame.ready           = (r_state == S_IDLE);
    assign o_reply.valid           = r_ov;
    assign o_reply.reply_word      = r_ow;
    assign o_reply.reply_valid_bytes = r_ovb;
    assign o_reply.reply_kind      = r_ok;
    assign o_reply.reply_end       = r_oe;

    logic out_free;
    logic last_byte;
    assign out_free  = !r_ov || o_reply.ready;
    assign last_byte = (r_pos + PW'(1)) == r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= 1'b0;
            r_ip      <= '0;
            r_mac     <= '0;
            r_arp_en  <= 1'b1;
            r_icmp_en <= 1'b1;
            r_udp_en  <= 1'b1;
            r_nbytes  <= '0;
            r_ovf     <= 1'b0;
            r_ov      <= 1'b0;
            r_kind    <= aiue_pkg::KIND_ARP;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aiue_pkg::CFG_LOCAL_IP:    r_ip      <= i_cfg_data[31:0];
                    aiue_pkg::CFG_LOCAL_MAC:   r_mac     <= i_cfg_data;
                    aiue_pkg::CFG_ARP_ENABLE:  r_arp_en  <= i_cfg_data[0];
                    aiue_pkg::CFG_ICMP_ENABLE: r_icmp_en <= i_cfg_data[0];
                    aiue_pkg::CFG_UDP_ENABLE:  r_udp_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ov && o_reply.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_frame.valid) begin
                        r_word  <= i_frame.frame_word;
                        r_n     <= (i_frame.valid_bytes > 4'd8) ? 4'd8 : i_frame.valid_bytes;
                        r_end   <= i_frame.frame_end;
                        r_k     <= '0;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_k != r_n) begin
                        if (r_nbytes < PW'(FRAME_BYTES)) begin
                            r_nbytes <= r_nbytes + PW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_k <= r_k + 4'd1;
                    end else if (r_end) begin
                        r_len    <= r_nbytes;
                        r_nbytes <= '0;
                        r_pos    <= '0;
                        r_ph     <= 1'b0;
                        r_state  <= S_HDR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_HDR: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_hdr[r_pos[5:0]] <= ram_rdata;
                        r_pos <= r_pos + PW'(1);
                        if (r_pos == PW'(HDR_BYTES - 1)) begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_ovf  <= 1'b0;
                    r_ipck <= '0;
                    r_l4ck <= '0;
                    r_ph   <= 1'b0;
                    r_bi   <= '0;
                    r_acc  <= '0;
                    r_sum  <= '0;
                    r_pass <= 1'b0;
                    if (d_arp) begin
                        r_kind  <= aiue_pkg::KIND_ARP;
                        r_pos   <= '0;
                        r_stop  <= PW'(42);
                        r_state <= S_EMIT;
                    end else if (d_icmp || d_udp) begin
                        r_kind  <= d_icmp ? aiue_pkg::KIND_ICMP : aiue_pkg::KIND_UDP;
                        r_proto <= r_hdr[23];
                        r_tot   <= d_icmp ? d_tl : d_ul + 16'd20;
                        r_pos   <= PW'(14);
                        r_stop  <= PW'(34);
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_pos[0]) begin
                            r_sum <= r_sum + aiue_pkg::SUM_W'(rb);
                        end else begin
                            r_sum <= r_sum + aiue_pkg::SUM_W'({rb, 8'h00});
                        end
                        r_pos <= r_pos + PW'(1);
                        if (last_byte) begin
                            if (!r_pass) begin
                                r_ipck <= aiue_pkg::fold_not(r_sum + (r_pos[0]
                                          ? aiue_pkg::SUM_W'(rb)
                                          : aiue_pkg::SUM_W'({rb, 8'h00})));
                                r_pass <= 1'b1;
                                if (r_kind == aiue_pkg::KIND_ICMP) begin
                                    r_sum  <= '0;
                                    r_pos  <= PW'(34);
                                    r_stop <= PW'(r_tot + 16'd14);
                                end else begin
                                    r_sum  <= aiue_pkg::SUM_W'(r_tot - 16'd3);
                                    r_pos  <= PW'(26);
                                    r_stop <= PW'(r_tot + 16'd14);
                                end
                            end else begin
                                r_pos   <= '0;
                                r_stop  <= PW'(r_tot + 16'd14);
                                r_state <= S_EMIT;
                                if ((r_kind == aiue_pkg::KIND_UDP) &&
                                    (aiue_pkg::fold_not(r_sum + (r_pos[0]
                                        ? aiue_pkg::SUM_W'(rb)
                                        : aiue_pkg::SUM_W'({rb, 8'h00}))) == 16'h0000)) begin
                                    r_l4ck <= 16'hFFFF;
                                end else begin
                                    r_l4ck <= aiue_pkg::fold_not(r_sum + (r_pos[0]
                                              ? aiue_pkg::SUM_W'(rb)
                                              : aiue_pkg::SUM_W'({rb, 8'h00})));
                                end
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if ((r_bi == 3'd7) || last_byte) begin
                        if (out_free) begin
                            r_ov  <= 1'b1;
                            r_ow  <= r_acc | ({56'h0, rb} << (6'd56 - {r_bi, 3'b000}));
                            r_ovb <= {1'b0, r_bi} + 4'd1;
                            r_ok  <= r_kind;
                            r_oe  <= last_byte;
                            r_acc <= '0;
                            r_bi  <= '0;
                            r_ph  <= 1'b0;
                            r_pos <= r_pos + PW'(1);
                            if (last_byte) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_acc <= r_acc | ({56'h0, rb} << (6'd56 - {r_bi, 3'b000}));
                        r_bi  <= r_bi + 3'd1;
                        r_ph  <= 1'b0;
                        r_pos <= r_pos + PW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/aiue_chk.sv]
// ----------------------------------------------------------------------------
// Responder port checker
// Checks the reply channel of the responder as seen at its ports.
// ----------------------------------------------------------------------------
module aiue_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_word,
    input logic [3:0]  i_out_vb,
    input logic [1:0]  i_out_kind,
    input logic        i_out_end
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Reply valid after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("Stalled reply changed.");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_kind != 2'd3)
        else $error("Bad reply kind.");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_end |-> i_out_vb == 4'd8)
        else $error("Short reply word before the end.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_vb != 4'd0 && i_out_vb <= 4'd8)
        else $error("Reply byte count out of range.");
endmodule

bind arp_icmp_udp_echo_responder_unit aiue_chk u_aiue_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_reply.valid),
    .i_out_ready (o_reply.ready),
    .i_out_word  (o_reply.reply_word),
    .i_out_vb    (o_reply.reply_valid_bytes),
    .i_out_kind  (o_reply.reply_kind),
    .i_out_end   (o_reply.reply_end)
);

[tb/tb_aiue_reply_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo responder reply checker
// Watches the configuration port and both channels, predicts every reply
// word from the frames that the responder accepts and compares each reply
// word, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_aiue_reply_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aiue_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aiue_pkg::CFG_DATA_W-1:0] i_cfg_data,
    aiue_in_if                              i_frame,
    aiue_out_if                             i_reply,
    output int                              o_fail_count,
    output int                              o_pending
);
    localparam int STORE_BYTES = aiue_pkg::FRAME_BYTES_DEF;
    localparam int MAX_WORDS = 64;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic [1:0]  kind;
        logic        last;
    } reply_word_t;

    reply_word_t expected_q[$];

    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic        arp_on;
    logic        icmp_on;
    logic        udp_on;

    logic [7:0] rx_bytes[STORE_BYTES];
    logic [7:0] tx_bytes[STORE_BYTES];
    int         rx_len;
    bit         rx_overflow;
    int         fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending = expected_q.size();

    function automatic logic [15:0] rx16(int o);
        return {rx_bytes[o], rx_bytes[o + 1]};
    endfunction

    function automatic logic [31:0] rx32(int o);
        return {rx16(o), rx16(o + 2)};
    endfunction

    function automatic void tx16(int o, logic [15:0] v);
        tx_bytes[o] = v[15:8];
        tx_bytes[o + 1] = v[7:0];
    endfunction

    function automatic void tx_own_mac(int o);
        for (int i = 0; i < 6; i++) tx_bytes[o + i] = own_mac[47 - 8 * i -: 8];
    endfunction

    function automatic int unsigned sum16(int unsigned s, int o, int len);
        for (int i = 0; i + 1 < len; i += 2) s += {tx_bytes[o + i], tx_bytes[o + i + 1]};
        if (len % 2 == 1) s += {tx_bytes[o + len - 1], 8'h00};
        return s;
    endfunction

    function automatic logic [15:0] ones_fold(int unsigned s);
        s = (s >> 16) + (s & 32'hFFFF);
        s = s + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic void tx_ip_header(int total, logic [7:0] proto);
        for (int i = 0; i < 6; i++) tx_bytes[i] = rx_bytes[6 + i];
        tx_own_mac(6);
        tx16(12, aiue_pkg::ETH_TYPE_IPV4);
        tx_bytes[14] = aiue_pkg::IP_VER_IHL;
        tx_bytes[15] = 8'h00;
        tx16(16, total[15:0]);
        tx16(18, 16'h0000);
        tx16(20, 16'h0000);
        tx_bytes[22] = aiue_pkg::IP_TTL;
        tx_bytes[23] = proto;
        tx16(24, 16'h0000);
        tx16(26, own_ip[31:16]);
        tx16(28, own_ip[15:0]);
        for (int i = 0; i < 4; i++) tx_bytes[30 + i] = rx_bytes[26 + i];
        tx16(24, ones_fold(sum16(0, 14, 20)));
    endfunction

    // Builds the reply in tx_bytes and returns its length, or 0 for no reply.
    function automatic int build_reply(output logic [1:0] kind);
        int tl;
        int ul;
        int unsigned s;
        logic [15:0] ck;
        kind = aiue_pkg::KIND_ARP;
        if (rx_len < 14) return 0;
        if (rx16(12) == aiue_pkg::ETH_TYPE_ARP) begin
            if (rx_len < 42 || !arp_on) return 0;
            if (rx16(20) != aiue_pkg::ARP_OP_REQ || rx32(38) != own_ip) return 0;
            for (int i = 0; i < 6; i++) tx_bytes[i] = rx_bytes[22 + i];
            tx_own_mac(6);
            tx16(12, aiue_pkg::ETH_TYPE_ARP);
            tx16(14, 16'd1);
            tx16(16, aiue_pkg::ETH_TYPE_IPV4);
            tx_bytes[18] = 8'd6;
            tx_bytes[19] = 8'd4;
            tx16(20, {8'h00, aiue_pkg::ARP_OP_REPLY});
            tx_own_mac(22);
            tx16(28, own_ip[31:16]);
            tx16(30, own_ip[15:0]);
            for (int i = 0; i < 6; i++) tx_bytes[32 + i] = rx_bytes[22 + i];
            for (int i = 0; i < 4; i++) tx_bytes[38 + i] = rx_bytes[28 + i];
            kind = aiue_pkg::KIND_ARP;
            return 42;
        end
        if (rx16(12) != aiue_pkg::ETH_TYPE_IPV4) return 0;
        if (rx_len < 34 || rx_bytes[14] != aiue_pkg::IP_VER_IHL || rx32(30) != own_ip) return 0;
        if (rx_bytes[23] == aiue_pkg::PROTO_ICMP) begin
            tl = rx16(16);
            if (!icmp_on || tl < 28 || 14 + tl > rx_len) return 0;
            if (rx_bytes[34] != aiue_pkg::ICMP_ECHO_REQ) return 0;
            tx_ip_header(tl, aiue_pkg::PROTO_ICMP);
            for (int i = 34; i < 14 + tl; i++) tx_bytes[i] = rx_bytes[i];
            tx_bytes[34] = aiue_pkg::ICMP_ECHO_REP;
            tx_bytes[35] = 8'h00;
            tx16(36, 16'h0000);
            tx16(36, ones_fold(sum16(0, 34, tl - 20)));
            kind = aiue_pkg::KIND_ICMP;
            return 14 + tl;
        end
        if (rx_bytes[23] == aiue_pkg::PROTO_UDP) begin
            if (!udp_on || rx_len < 42) return 0;
            ul = rx16(38);
            if (ul < 8 || 34 + ul > rx_len) return 0;
            tx_ip_header(ul + 20, aiue_pkg::PROTO_UDP);
            for (int i = 34; i < 34 + ul; i++) tx_bytes[i] = rx_bytes[i];
            tx16(34, rx16(36));
            tx16(36, rx16(34));
            tx16(40, 16'h0000);
            s = sum16(0, 26, 8) + 17 + ul;
            ck = ones_fold(sum16(s, 34, ul));
            if (ck == 16'h0000) ck = 16'hFFFF;
            tx16(40, ck);
            kind = aiue_pkg::KIND_UDP;
            return 34 + ul;
        end
        return 0;
    endfunction

    function automatic void take_frame_word(logic [63:0] w, logic [3:0] code, logic fin);
        int n;
        int len;
        logic [1:0] kind;
        reply_word_t r;
        n = (code > 8) ? 8 : code;
        for (int k = 0; k < n; k++) begin
            if (rx_len < STORE_BYTES) begin
                rx_bytes[rx_len] = w[63 - 8 * k -: 8];
                rx_len++;
            end else begin
                rx_overflow = 1'b1;
            end
        end
        if (!fin) return;
        len = rx_overflow ? 0 : build_reply(kind);
        rx_len = 0;
        rx_overflow = 1'b0;
        if (len == 0 || len > MAX_WORDS * 8) return;
        for (int k = 0; k < (len + 7) / 8; k++) begin
            r.nbytes = 4'((len - 8 * k < 8) ? len - 8 * k : 8);
            r.word = '0;
            for (int b = 0; b < r.nbytes; b++) r.word[63 - 8 * b -: 8] = tx_bytes[8 * k + b];
            r.kind = kind;
            r.last = (8 * k + 8 >= len);
            expected_q.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        reply_word_t exp_r;
        if (!i_rst_n) begin
            own_ip <= '0;
            own_mac <= '0;
            arp_on <= 1'b1;
            icmp_on <= 1'b1;
            udp_on <= 1'b1;
            rx_len = 0;
            rx_overflow = 1'b0;
            fail_cnt = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aiue_pkg::CFG_LOCAL_IP: own_ip <= i_cfg_data[31:0];
                    aiue_pkg::CFG_LOCAL_MAC: own_mac <= i_cfg_data[47:0];
                    aiue_pkg::CFG_ARP_ENABLE: arp_on <= i_cfg_data[0];
                    aiue_pkg::CFG_ICMP_ENABLE: icmp_on <= i_cfg_data[0];
                    aiue_pkg::CFG_UDP_ENABLE: udp_on <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_frame.valid && i_frame.ready) begin
                take_frame_word(i_frame.frame_word, i_frame.valid_bytes, i_frame.frame_end);
            end
            if (i_reply.valid && i_reply.ready) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("Reply word with none expected: word %h bytes %0d kind %0d end %b",
                                 i_reply.reply_word, i_reply.reply_valid_bytes,
                                 i_reply.reply_kind, i_reply.reply_end);
                    end
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_reply.reply_word !== exp_r.word
                            || i_reply.reply_valid_bytes !== exp_r.nbytes
                            || i_reply.reply_kind !== exp_r.kind
                            || i_reply.reply_end !== exp_r.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("Reply mismatch: expected %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                                     exp_r.word, exp_r.nbytes, exp_r.kind, exp_r.last,
                                     i_reply.reply_word, i_reply.reply_valid_bytes,
                                     i_reply.reply_kind, i_reply.reply_end);
                        end
                    end
                end
            end
        end
    end

endmodule

[tb/tb_arp_icmp_udp_echo_responder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo responder testbench
// Sends directed and random ARP, ICMP, UDP and malformed frames in bursts
// under several register settings, stalls the reply side, and reports the
// verdict from the failure count of the reply checker.
// ----------------------------------------------------------------------------
module tb_arp_icmp_udp_echo_responder_unit;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 3000;
    localparam int WORD_TARGET = 430;

    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  IP_VER_IHL_OPT = 8'h46;
    localparam logic [15:0] ETH_TYPE_IPV6  = 16'h86DD;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [aiue_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [aiue_pkg::CFG_DATA_W-1:0] i_cfg_data;

    aiue_in_if  frame_ch ();
    aiue_out_if reply_ch ();

    int fail_count;
    int pending;
    int cycles = 0;
    int words_sent;
    int burst_left;
    bit hold_reply;

    logic [7:0]  pkt[$];
    logic [31:0] own_ip;

    arp_icmp_udp_echo_responder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_frame     (frame_ch),
        .o_reply     (reply_ch)
    );

    tb_aiue_reply_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_frame      (frame_ch),
        .i_reply      (reply_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Reply side: changing stall modes, plus one long hold-off on request.
    initial begin
        int stall_mode;
        reply_ch.ready = 1'b0;
        stall_mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reply) begin
                reply_ch.ready <= 1'b0;
                repeat (4000) @(posedge i_clk);
                hold_reply = 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
                case (stall_mode)
                    0: reply_ch.ready <= 1'b1;
                    1: reply_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: reply_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic void push16(logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void push32(logic [31:0] v);
        push16(v[31:16]);
        push16(v[15:0]);
    endfunction

    function automatic void push_rand(int n);
        for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
    endfunction

    function automatic void eth_header(logic [15:0] etype);
        pkt.delete();
        push_rand(12);
        push16(etype);
    endfunction

    function automatic void make_arp(logic [15:0] op, logic [31:0] tip, int pad);
        eth_header(aiue_pkg::ETH_TYPE_ARP);
        push16(16'd1);
        push16(aiue_pkg::ETH_TYPE_IPV4);
        pkt.push_back(8'd6);
        pkt.push_back(8'd4);
        push16(op);
        push_rand(10);
        push_rand(6);
        push32(tip);
        push_rand(pad);
    endfunction

    function automatic void make_ipv4(logic [7:0] vihl, logic [7:0] proto,
                                      logic [31:0] dst, int tl);
        eth_header(aiue_pkg::ETH_TYPE_IPV4);
        pkt.push_back(vihl);
        pkt.push_back(8'($urandom));
        push16(tl[15:0]);
        push_rand(4);
        pkt.push_back(8'($urandom));
        pkt.push_back(proto);
        push_rand(6);
        push32(dst);
    endfunction

    // ICMP message of type msg_type; tl_delta bends the IP total length away from the truth.
    function automatic void make_icmp(logic [7:0] msg_type, logic [31:0] dst,
                                      int n, int tl_delta, int pad);
        make_ipv4(aiue_pkg::IP_VER_IHL, aiue_pkg::PROTO_ICMP, dst, 28 + n + tl_delta);
        pkt.push_back(msg_type);
        push_rand(7 + n);
        push_rand(pad);
    endfunction

    function automatic void make_udp(logic [31:0] dst, int n, int ul_delta, int pad);
        make_ipv4(aiue_pkg::IP_VER_IHL, aiue_pkg::PROTO_UDP, dst, 28 + n);
        push32($urandom);
        push16(16'(8 + n + ul_delta));
        push_rand(2 + n);
        push_rand(pad);
    endfunction

    task automatic send_word(logic [63:0] w, logic [3:0] code, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                frame_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        frame_ch.valid <= 1'b1;
        frame_ch.frame_word <= w;
        frame_ch.valid_bytes <= code;
        frame_ch.frame_end <= fin;
        do @(posedge i_clk); while (!frame_ch.ready);
        words_sent++;
    endtask

    task automatic send_frame();
        int pos;
        int cnt;
        logic [3:0] code;
        logic [63:0] w;
        pos = 0;
        while (pos < pkt.size()) begin
            if ($urandom_range(0, 39) == 0) send_word({$urandom, $urandom}, 4'd0, 1'b0);
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 8;
            if (cnt > pkt.size() - pos) cnt = pkt.size() - pos;
            code = 4'(cnt);
            if (cnt == 8 && $urandom_range(0, 9) == 0) code = 4'($urandom_range(9, 15));
            w = {$urandom, $urandom};
            for (int b = 0; b < cnt; b++) w[63 - 8 * b -: 8] = pkt[pos + b];
            pos += cnt;
            send_word(w, code, pos == pkt.size());
        end
    endtask

    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] ip, logic [47:0] mac, logic arp_on,
                              logic icmp_on, logic udp_on);
        logic [aiue_pkg::CFG_DATA_W-1:0] vals[5];
        logic [aiue_pkg::CFG_IDX_W-1:0]  idx[5];
        vals = '{{16'h0, ip}, mac, {47'h0, arp_on}, {47'h0, icmp_on}, {47'h0, udp_on}};
        idx = '{aiue_pkg::CFG_LOCAL_IP, aiue_pkg::CFG_LOCAL_MAC, aiue_pkg::CFG_ARP_ENABLE,
                aiue_pkg::CFG_ICMP_ENABLE, aiue_pkg::CFG_UDP_ENABLE};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        own_ip = ip;
    endtask

    function automatic int payload_len();
        if ($urandom_range(0, 39) == 0) return $urandom_range(64, 470);
        return $urandom_range(0, 48);
    endfunction

    function automatic logic [31:0] pick_dst();
        return ($urandom_range(0, 5) == 0) ? $urandom : own_ip;
    endfunction

    task automatic random_frame();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
            make_arp(($urandom_range(0, 5) == 0) ? 16'($urandom) : aiue_pkg::ARP_OP_REQ,
                     pick_dst(), $urandom_range(0, 18));
            if ($urandom_range(0, 9) == 0) pkt = pkt[0:$urandom_range(14, 41)];
        end else if (sel < 11) begin
            make_icmp(($urandom_range(0, 5) == 0) ? 8'($urandom) : aiue_pkg::ICMP_ECHO_REQ,
                      pick_dst(), payload_len(),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) - 20 : 0,
                      $urandom_range(0, 8));
        end else if (sel < 17) begin
            make_udp(pick_dst(), payload_len(),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) - 20 : 0,
                     $urandom_range(0, 8));
        end else if (sel < 19) begin
            make_ipv4(($urandom_range(0, 1) == 0) ? 8'($urandom) : aiue_pkg::IP_VER_IHL,
                      ($urandom_range(0, 1) == 0) ? 8'($urandom) : aiue_pkg::PROTO_UDP,
                      own_ip, $urandom_range(20, 80));
            push_rand($urandom_range(0, 40));
        end else begin
            pkt.delete();
            push_rand(($urandom_range(0, 3) == 0) ? $urandom_range(500, 560)
                                                  : $urandom_range(1, 80));
        end
        send_frame();
    endtask

    initial begin
        int stop_at;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        frame_ch.valid = 1'b0;
        frame_ch.frame_word = '0;
        frame_ch.valid_bytes = '0;
        frame_ch.frame_end = 1'b0;
        words_sent = 0;
        burst_left = 0;
        hold_reply = 1'b0;
        own_ip = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first: address zero, every kind enabled.
        make_arp(aiue_pkg::ARP_OP_REQ, 32'h0, 0);
        send_frame();
        wait_idle();

        write_regs(32'hC0A8_010A, 48'h0200_1122_3344, 1'b1, 1'b1, 1'b1);
        make_arp(aiue_pkg::ARP_OP_REQ, own_ip, 0);
        send_frame();
        make_arp({8'h00, aiue_pkg::ARP_OP_REPLY}, own_ip, 4);
        send_frame();
        make_arp(aiue_pkg::ARP_OP_REQ, own_ip ^ 32'h1, 0);
        send_frame();
        make_arp(aiue_pkg::ARP_OP_REQ, own_ip, 0);
        void'(pkt.pop_back());
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REQ, own_ip, 0, 0, 0);
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REQ, own_ip, 37, 0, 6);
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REQ, own_ip, 470, 0, 0);
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REP, own_ip, 8, 0, 0);
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REQ, own_ip, 8, -9, 0);
        send_frame();
        make_icmp(aiue_pkg::ICMP_ECHO_REQ, own_ip, 8, 1, 0);
        send_frame();
        make_udp(own_ip, 0, 0, 0);
        send_frame();
        make_udp(own_ip, 21, 0, 3);
        send_frame();
        make_udp(own_ip, 470, 0, 0);
        send_frame();
        make_udp(own_ip, 4, -5, 0);
        send_frame();
        make_udp(own_ip, 4, 1, 0);
        send_frame();
        make_udp(own_ip ^ 32'h8000_0000, 4, 0, 0);
        send_frame();
        make_ipv4(IP_VER_IHL_OPT, aiue_pkg::PROTO_UDP, own_ip, 40);
        push_rand(20);
        send_frame();
        make_ipv4(aiue_pkg::IP_VER_IHL, PROTO_TCP, own_ip, 40);
        push_rand(20);
        send_frame();
        eth_header(ETH_TYPE_IPV6);
        push_rand(40);
        send_frame();
        pkt.delete();
        push_rand(10);
        send_frame();
        make_udp(own_ip, 480, 0, 10);
        send_frame();
        wait_idle();

        // Extremes, then everything off, then random settings.
        write_regs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
        hold_reply = 1'b1;
        stop_at = words_sent + 20;
        while (words_sent < stop_at) random_frame();
        wait_idle();

        write_regs(32'h0, 48'h0, 1'b0, 1'b0, 1'b0);
        stop_at = words_sent + 8;
        while (words_sent < stop_at) random_frame();
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            write_regs($urandom, {$urandom, $urandom}, phase != 1, phase != 2, phase != 3);
            stop_at = words_sent + 8;
            while (words_sent < stop_at) random_frame();
            wait_idle();
        end

        write_regs($urandom, {$urandom, $urandom}, 1'b1, 1'b1, 1'b1);
        do random_frame(); while (words_sent < WORD_TARGET);
        wait_idle();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
